// File: rtl/fcms_pkg.sv
// Package: sketch geometry, register indexes, lane status types.
package fcms_pkg;
  localparam int unsigned Rows = 2;
  localparam int unsigned Leaves = 4096;
  localparam int unsigned Fanout = 8;
  localparam int unsigned Size1 = (Leaves + Fanout - 1) / Fanout;
  localparam int unsigned Size2 = (Size1 + Fanout - 1) / Fanout;
  localparam int unsigned LeafW = $clog2(Leaves);
  localparam int unsigned Idx1W = $clog2(Size1);
  localparam int unsigned Idx2W = $clog2(Size2);
  localparam int unsigned ClrW = LeafW + 1;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    RegHeavyThreshold = 2'd0,
    RegFirstMax       = 2'd1,
    RegSecondMax      = 2'd2,
    RegUnused         = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StClear = 2'd0,
    StIdle  = 2'd1,
    StRead  = 2'd2,
    StWrite = 2'd3
  } state_e;

  typedef struct packed {
    logic clear;
    logic [ClrW-1:0] clr_addr;
    logic rd;
    logic wr;
    logic ins;
  } lane_ctrl_t;
endpackage

// File: rtl/fcms_if.sv
// Valid/ready channel interfaces for items, results and configuration.
interface fcms_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [11:0] row0_leaf;
  logic [11:0] row1_leaf;
  modport source (output valid, opcode, row0_leaf, row1_leaf, input ready);
  modport sink (input valid, opcode, row0_leaf, row1_leaf, output ready);
endinterface

interface fcms_out_if;
  logic valid;
  logic ready;
  logic [31:0] estimate;
  logic heavy_hitter;
  modport source (output valid, estimate, heavy_hitter, input ready);
  modport sink (input valid, estimate, heavy_hitter, output ready);
endinterface

interface fcms_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/fcms_lane.sv
// One row of the sketch: three counter stages read, updated and summed.
module fcms_lane (
  input  logic clk_i,
  input  fcms_pkg::lane_ctrl_t ctrl_i,
  input  logic [fcms_pkg::LeafW-1:0] leaf_i,
  input  logic [7:0] max1_i,
  input  logic [15:0] max2_i,
  input  logic [31:0] thr_i,
  output logic [31:0] sum_o,
  output logic heavy_o
);
  import fcms_pkg::*;

  logic [8:0]  mem0 [Leaves];
  logic [16:0] mem1 [Size1];
  logic [32:0] mem2 [Size2];
  logic [8:0]  rd0_q;
  logic [16:0] rd1_q;
  logic [32:0] rd2_q;
  logic [LeafW-1:0] a0;
  logic [Idx1W-1:0] a1;
  logic [Idx2W-1:0] a2;
  logic [8:0]  w0;
  logic [16:0] w1;
  logic [32:0] w2;
  logic we0, we1, we2;
  logic [33:0] sum;
  logic [32:0] inc2;
  logic [16:0] inc1;
  logic [8:0]  inc0;

  assign a0 = ctrl_i.clear ? ctrl_i.clr_addr[LeafW-1:0] : leaf_i;
  assign a1 = ctrl_i.clear ? ctrl_i.clr_addr[Idx1W-1:0] : leaf_i[LeafW-1 -: Idx1W];
  assign a2 = ctrl_i.clear ? ctrl_i.clr_addr[Idx2W-1:0] : leaf_i[LeafW-1 -: Idx2W];

  always_ff @(posedge clk_i) begin
    if (we0) mem0[a0] <= w0;
    if (we1) mem1[a1] <= w1;
    if (we2) mem2[a2] <= w2;
    if (ctrl_i.rd) begin
      rd0_q <= mem0[a0];
      rd1_q <= mem1[a1];
      rd2_q <= mem2[a2];
    end
  end

  // On clear, zero the counters; else walk up: stop at the first counter not overflowed, bump it on insert.
  always_comb begin
    we0 = 1'b0; we1 = 1'b0; we2 = 1'b0;
    inc0 = {1'b0, rd0_q[7:0]} + 9'd1;
    inc1 = {1'b0, rd1_q[15:0]} + 17'd1;
    inc2 = {1'b0, rd2_q[31:0]} + 33'd1;
    w0 = '0; w1 = '0; w2 = '0;
    sum = '0;
    if (ctrl_i.clear) begin
      we0 = 1'b1;
      we1 = ctrl_i.clr_addr < ClrW'(Size1);
      we2 = ctrl_i.clr_addr < ClrW'(Size2);
    end else if (!rd0_q[8]) begin
      w0 = (inc0 >= {1'b0, max1_i}) ? {1'b1, max1_i} : {1'b0, inc0[7:0]};
      we0 = ctrl_i.wr && ctrl_i.ins;
      sum = ctrl_i.ins ? 34'(w0[7:0]) : 34'(rd0_q[7:0]);
    end else if (!rd1_q[16]) begin
      w1 = (inc1 >= {1'b0, max2_i}) ? {1'b1, max2_i} : {1'b0, inc1[15:0]};
      we1 = ctrl_i.wr && ctrl_i.ins;
      sum = 34'(rd0_q[7:0]) + (ctrl_i.ins ? 34'(w1[15:0]) : 34'(rd1_q[15:0]));
    end else if (!rd2_q[32]) begin
      w2 = (inc2 >= 33'hFFFFFFFF) ? {1'b1, 32'hFFFFFFFF} : {1'b0, inc2[31:0]};
      we2 = ctrl_i.wr && ctrl_i.ins;
      sum = 34'(rd0_q[7:0]) + 34'(rd1_q[15:0])
          + (ctrl_i.ins ? 34'(w2[31:0]) : 34'(rd2_q[31:0]));
    end else begin
      sum = 34'(rd0_q[7:0]) + 34'(rd1_q[15:0]);
    end
  end

  assign sum_o = (sum[33:32] != 2'd0) ? 32'hFFFFFFFF : sum[31:0];
  assign heavy_o = ctrl_i.ins && (sum_o > thr_i);
endmodule

// File: rtl/fcms_merge.sv
// Merge lane sums: minimum estimate and any heavy flag, into the output register.
module fcms_merge (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic [fcms_pkg::Rows-1:0][31:0] sum_i,
  input  logic [fcms_pkg::Rows-1:0] heavy_i,
  fcms_out_if.source out
);
  import fcms_pkg::*;

  logic [31:0] best;
  logic valid_q;
  logic [31:0] est_q;
  logic hh_q;

  always_comb begin
    best = 32'hFFFFFFFF;
    for (int r = 0; r < Rows; r++) begin
      if (sum_i[r] < best) best = sum_i[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      est_q <= best;
      hh_q <= |heavy_i;
    end
  end

  assign out.valid = valid_q;
  assign out.estimate = est_q;
  assign out.heavy_hitter = hh_q;
endmodule

// File: rtl/feedforward_count_min_sketch_unit.sv
// Top level: feed-forward count-min sketch with one lane per row.
// Usage:
//   in_ch  : items (opcode, row0_leaf, row1_leaf), valid/ready.
//   out_ch : one result per item (estimate, heavy_hitter), valid/ready.
//   cfg_ch : register writes (index, data); always ready; write only when idle.
// Each row lane reads its three stage counters at the accepting edge (registered
// read of the counter memories), holds them through the read state, then updates
// the open counter and forms its path sum in the write state. A merge stage takes
// the minimum over rows into the output register, loaded at the end of the write
// state. Input ready waits for the idle state and for the output register to
// empty, so a new item is taken only after the receiver has taken the last result.
// After reset a clearing pass writes every counter to zero, one address per
// cycle over all 4096 leaf addresses; no item is taken then.
// When the receiver stalls, the result waits in the output register and no
// new item is accepted until it is taken.
module feedforward_count_min_sketch_unit (
  input  logic clk_i,
  input  logic rst_ni,
  fcms_in_if.sink in_ch,
  fcms_out_if.source out_ch,
  fcms_cfg_if.sink cfg_ch
);
  import fcms_pkg::*;

  state_e state_q, state_d;
  logic [ClrW-1:0] clr_q, clr_d;
  logic [31:0] thr_q;
  logic [7:0] max1_q;
  logic [15:0] max2_q;
  logic ins_q;
  logic [Rows-1:0][LeafW-1:0] leaf_q;
  lane_ctrl_t ctrl;
  logic [Rows-1:0][31:0] sums;
  logic [Rows-1:0] heavy;
  logic accept;
  logic load;

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    unique case (state_q)
      StClear: begin
        clr_d = clr_q + ClrW'(1);
        if (clr_q == ClrW'(Leaves - 1)) state_d = StIdle;
      end
      StIdle:  if (accept) state_d = StRead;
      StRead:  state_d = StWrite;
      StWrite: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_q == StIdle) && !out_ch.valid;
    ctrl.clear = (state_q == StClear);
    ctrl.clr_addr = clr_q;
    ctrl.rd = accept;
    ctrl.wr = (state_q == StWrite);
    ctrl.ins = ins_q;
    load = (state_q == StWrite);
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      thr_q <= 32'd1000;
      max1_q <= 8'd254;
      max2_q <= 16'd65534;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      if (cfg_ch.valid) begin
        unique case (cfg_reg_e'(cfg_ch.index))
          RegHeavyThreshold: thr_q <= cfg_ch.data;
          RegFirstMax:       max1_q <= cfg_ch.data[7:0];
          RegSecondMax:      max2_q <= cfg_ch.data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ins_q <= !in_ch.opcode;
      for (int r = 0; r < Rows; r++) begin
        leaf_q[r] <= (r % 2 == 0) ? in_ch.row0_leaf[LeafW-1:0] : in_ch.row1_leaf[LeafW-1:0];
      end
    end
  end

  for (genvar r = 0; r < Rows; r++) begin : g_lane
    logic [LeafW-1:0] lane_leaf;
    assign lane_leaf = accept ? ((r % 2 == 0) ? in_ch.row0_leaf[LeafW-1:0]
                                              : in_ch.row1_leaf[LeafW-1:0])
                              : leaf_q[r];
    fcms_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .leaf_i (lane_leaf),
      .max1_i (max1_q),
      .max2_i (max2_q),
      .thr_i  (thr_q),
      .sum_o  (sums[r]),
      .heavy_o(heavy[r])
    );
  end

  fcms_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .sum_i  (sums),
    .heavy_i(heavy),
    .out    (out_ch)
  );
endmodule

// File: tb/tb_top.sv
// Testbench for the feed-forward count-min sketch unit: directed and random traffic, scoreboard check.
`timescale 1ns / 100ps

class sketch_scoreboard;
  int unsigned counts[3][fcms_pkg::Rows][fcms_pkg::Leaves];
  bit          saturated[3][fcms_pkg::Rows][fcms_pkg::Leaves];
  int unsigned stage_max[3];
  int unsigned threshold;
  logic [32:0] pending_q[$];  // {heavy_hitter, estimate}
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned heavy_seen;

  function new();
    threshold    = 1000;
    stage_max[0] = 254;
    stage_max[1] = 65534;
    stage_max[2] = 32'hFFFF_FFFF;
    mismatches   = 0;
    results_seen = 0;
    heavy_seen   = 0;
  endfunction

  function void write_reg(fcms_pkg::cfg_reg_e idx, logic [31:0] data);
    case (idx)
      fcms_pkg::RegHeavyThreshold: threshold = data;
      fcms_pkg::RegFirstMax:       stage_max[0] = data[7:0];
      fcms_pkg::RegSecondMax:      stage_max[1] = data[15:0];
      default: ;
    endcase
  endfunction

  // Walk one row up from its leaf; bump the first open counter when inserting.
  function int unsigned path_sum(int r, logic [11:0] leaf, bit ins);
    longint unsigned sum;
    longint unsigned nv;
    int idx;
    sum = 0;
    for (int s = 0; s < 3; s++) begin
      idx = leaf >> (3 * s);
      if (saturated[s][r][idx]) begin
        if (s == 2) break;
        sum += counts[s][r][idx];
        continue;
      end
      if (ins) begin
        nv = longint'(counts[s][r][idx]) + 1;
        if (nv >= stage_max[s]) begin
          counts[s][r][idx] = stage_max[s];
          saturated[s][r][idx] = 1'b1;
        end else begin
          counts[s][r][idx] = nv;
        end
      end
      sum += counts[s][r][idx];
      break;
    end
    if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
    return sum;
  endfunction

  function void note_item(logic op, logic [11:0] leaf0, logic [11:0] leaf1);
    int unsigned best;
    int unsigned sum;
    bit heavy;
    bit ins;
    ins   = (op == 1'b0);
    best  = 32'hFFFF_FFFF;
    heavy = 1'b0;
    for (int r = 0; r < fcms_pkg::Rows; r++) begin
      sum = path_sum(r, (r % 2) ? leaf1 : leaf0, ins);
      if (sum < best) best = sum;
      if (ins && sum > threshold) heavy = 1'b1;
    end
    pending_q.insert(pending_q.size(), {heavy, best[31:0]});
  endfunction

  function void check_result(logic [31:0] est, logic heavy);
    logic [32:0] exp_v;
    results_seen++;
    if (heavy === 1'b1) heavy_seen++;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: estimate %0d heavy %b", est, heavy);
      return;
    end
    exp_v = pending_q.pop_front();
    if (est !== exp_v[31:0] || heavy !== exp_v[32]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: estimate exp %0d got %0d, heavy exp %b got %b",
                 exp_v[31:0], est, exp_v[32], heavy);
    end
  endfunction
endclass

module tb_top;
  import fcms_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Drain = 10;

  logic clk_i;
  logic rst_ni;
  fcms_in_if  in_ch ();
  fcms_out_if out_ch ();
  fcms_cfg_if cfg_ch ();

  feedforward_count_min_sketch_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  sketch_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned stall_mode = 0;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: check on handshake, then stall on its own pattern.
  always @(posedge clk_i) begin
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result(out_ch.estimate, out_ch.heavy_hitter);
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 1) != 0);
      default: out_ch.ready <= ((cycles % 7) < 2);
    endcase
  end

  task automatic send_item(logic op, logic [11:0] leaf0, logic [11:0] leaf1);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.row0_leaf <= leaf0;
    in_ch.row1_leaf <= leaf1;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.note_item(op, leaf0, leaf1);
    items_sent++;
    if (op) queries_sent++;
  endtask

  // Hold until every result is in, then let the pipeline settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  // Leave valid high; the caller drops it after the last write.
  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  task automatic set_regs(logic [31:0] thr, logic [31:0] m1, logic [31:0] m2);
    drain_results();
    write_reg(RegHeavyThreshold, thr);
    write_reg(RegFirstMax, m1);
    write_reg(RegSecondMax, m2);
    write_reg(RegUnused, 32'hFFFF_FFFF);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [11:0] pick_leaf(logic [11:0] base);
    if ($urandom_range(0, 9) < 7) return base + 12'($urandom_range(0, 15));
    return 12'($urandom());
  endfunction

  task automatic random_phase(int unsigned n);
    logic [11:0] base0;
    logic [11:0] base1;
    base0 = 12'($urandom());
    base1 = 12'($urandom());
    repeat (n) begin
      if ($urandom_range(0, 31) == 0) begin
        base0 = 12'($urandom());
        base1 = 12'($urandom());
      end
      send_item($urandom_range(0, 9) < 3, pick_leaf(base0), pick_leaf(base1));
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = 1'b0;
    in_ch.row0_leaf = '0;
    in_ch.row1_leaf = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = RegHeavyThreshold;
    cfg_ch.data     = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes under reset settings.
    send_item(1'b0, 12'h000, 12'hFFF);
    send_item(1'b0, 12'hFFF, 12'h000);
    send_item(1'b1, 12'h000, 12'hFFF);
    send_item(1'b0, 12'hAAA, 12'h555);
    send_item(1'b1, 12'h555, 12'hAAA);
    // Tiny maxima: push one leaf past the lower stages' overflow into the top stage.
    set_regs(32'd3, 32'd2, 32'd2);
    repeat (8) send_item(1'b0, 12'h123, 12'h123);
    send_item(1'b1, 12'h123, 12'h124);
    // Lower the maximum below stored counts.
    set_regs(32'd0, 32'd1, 32'd1);
    send_item(1'b0, 12'h124, 12'h123);
    send_item(1'b1, 12'h124, 12'h123);
    // Zero maxima: first- and second-stage counters saturate on first increment.
    set_regs(32'hFFFF_FFFF, 32'd0, 32'd0);
    send_item(1'b0, 12'h800, 12'h7FF);
    send_item(1'b0, 12'h800, 12'h7FF);
    send_item(1'b1, 12'h800, 12'h7FF);

    set_regs(32'd1000, 32'd254, 32'd65534);
    random_phase(150);
    set_regs(32'd0, 32'd1, 32'd1);
    random_phase(150);
    set_regs(32'd20, 32'd3, 32'd5);
    random_phase(150);
    set_regs(32'hFFFF_FFFF, 32'd255, 32'd65535);
    random_phase(150);
    set_regs(32'd5, 32'd0, 32'd0);
    random_phase(150);
    set_regs(32'd50, 32'd2, 32'd3);
    random_phase(150);
    set_regs(32'd10, 32'd4, 32'd1);
    random_phase(150);
    set_regs(32'd100, 32'hFFFF_FF02, 32'hFFFF_0002);
    random_phase(150);
    set_regs(32'($urandom_range(0, 200)), 32'd6, 32'd9);
    random_phase(150);

    drain_results();
    $display("%0d items (%0d queries) sent, %0d results checked, %0d heavy flags",
             items_sent, queries_sent, sb.results_seen, sb.heavy_seen);
    $display("thirteen register settings incl. zero and full-scale maxima, %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/fcms_pkg.sv
rtl/fcms_if.sv
rtl/fcms_lane.sv
rtl/fcms_merge.sv
rtl/feedforward_count_min_sketch_unit.sv
tb/tb_top.sv
